// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [7:0] {
    OP_NOP   = 8'd0,
    OP_LOAD  = 8'd1,
    OP_LDIMM = 8'd2,
    OP_STORE = 8'd3,
    OP_JMP   = 8'd4,
    OP_JMPNZ = 8'd5,
    OP_PUSH  = 8'd6,
    OP_POP   = 8'd7,
    OP_ADD   = 8'd8,
    OP_SUB   = 8'd9,
    OP_XOR   = 8'd10,
    OP_AND   = 8'd11
  } opcode_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  opcode;
    logic [7:0]  dest_field;
    logic [7:0]  src_a;
    logic [7:0]  src_b;
    logic [7:0]  mem_addr;
    logic [31:0] mem_wdata;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  next_pc;
    logic        halted;
    logic [31:0] return_value;
    logic [31:0] read_data;
    logic        bad_opcode;
  } out_item_t;

  typedef struct packed {
    logic        is_alu;
    logic        bad;
    logic [31:0] result;
  } alu_res_t;

endpackage

// ===== rtl/tsc_if.sv =====
interface tsc_in_if;
  logic               valid;
  logic               ready;
  tsc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsc_out_if;
  logic               valid;
  logic               ready;
  tsc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tiny_stack_cpu_execute.sv =====
// Executes one instruction or data-memory command per transfer and gives one result per
// transfer, at one item per cycle sustained unless the output stalls. The issue stage reads
// the register file (two copies, one per source operand), the stack and the data memory;
// the execute stage computes and writes back as the result moves into the output register.
// A write-back to an entry read by the following item is forwarded. Register file and stack
// read as zero until written; data memory words read before any write are undefined.
module tiny_stack_cpu_execute #(
  parameter int NUM_REGS         = 16,
  parameter int STACK_DEPTH      = 16,
  parameter int DATA_WORDS       = 256,
  parameter int PROG_LEN         = 32,
  parameter int RETURN_REG_INDEX = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsc_in_if.sink     in_i,
  tsc_out_if.source  out_o
);

  localparam int RW = $clog2(NUM_REGS);
  localparam int SW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int DW = $clog2(DATA_WORDS);

  logic                accept;
  logic                advance;

  logic                s1_vld_q;
  tsc_pkg::in_item_t   s1_q;
  logic [SW-1:0]       s1_saddr_q;

  logic [SW-1:0]       sp_q, sp_d;
  logic [7:0]          pc_q, pc_d;
  logic [31:0]         ret_q, ret_d;

  logic [NUM_REGS-1:0]    rf_vld_q;
  logic [STACK_DEPTH-1:0] st_vld_q;

  // last write to each store, for the item whose read overlapped it
  logic                rf_fwd_vld_q;
  logic [RW-1:0]       rf_fwd_addr_q;
  logic [31:0]         rf_fwd_data_q;
  logic                st_fwd_vld_q;
  logic [SW-1:0]       st_fwd_addr_q;
  logic [31:0]         st_fwd_data_q;
  logic                dm_fwd_vld_q;
  logic [DW-1:0]       dm_fwd_addr_q;
  logic [31:0]         dm_fwd_data_q;

  logic                out_vld_q;
  tsc_pkg::out_item_t  out_q, out_d;

  logic [31:0]         rf_a_raw, rf_b_raw, st_raw, dm_raw;
  logic [31:0]         op_a, op_b, st_val, dm_val;

  logic                is_exec, is_wr, is_rd;
  logic                op_load, op_ldimm, op_store, op_jmp, op_jmpnz, op_push, op_pop;
  tsc_pkg::alu_res_t   alu_res;

  logic                rf_we;
  logic [31:0]         rf_wdata;
  logic                st_we;
  logic                dm_we;
  logic [DW-1:0]       dm_waddr;
  logic [31:0]         dm_wdata;
  logic [7:0]          dm_rd_addr;
  logic                to_ret;
  logic [7:0]          npc;

  logic                in_push, in_pop;
  logic [SW-1:0]       sp_inc, sp_dec;
  logic [7:0]          in_dm_addr;

  // ---------------- issue stage ----------------
  assign advance     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || advance;
  assign accept      = in_i.valid && in_i.ready;

  assign in_push = (tsc_pkg::cmd_e'(in_i.data.cmd) == tsc_pkg::CMD_EXEC) &&
                   (tsc_pkg::opcode_e'(in_i.data.opcode) == tsc_pkg::OP_PUSH);
  assign in_pop  = (tsc_pkg::cmd_e'(in_i.data.cmd) == tsc_pkg::CMD_EXEC) &&
                   (tsc_pkg::opcode_e'(in_i.data.opcode) == tsc_pkg::OP_POP);

  assign sp_inc = (sp_q == SW'(STACK_DEPTH - 1)) ? '0 : sp_q + SW'(1);
  assign sp_dec = (sp_q == '0) ? SW'(STACK_DEPTH - 1) : sp_q - SW'(1);

  always_comb begin
    sp_d = sp_q;
    if (accept && in_push) begin
      sp_d = sp_inc;
    end else if (accept && in_pop) begin
      sp_d = sp_dec;
    end
  end

  assign in_dm_addr = (tsc_pkg::cmd_e'(in_i.data.cmd) == tsc_pkg::CMD_EXEC) ?
                      in_i.data.src_b : in_i.data.mem_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      sp_q     <= '0;
    end else begin
      sp_q <= sp_d;
      if (accept) begin
        s1_vld_q <= 1'b1;
      end else if (advance) begin
        s1_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q       <= in_i.data;
      s1_saddr_q <= in_pop ? sp_dec : sp_q;
    end
  end

  // ---------------- stores ----------------
  tsc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_q.dest_field[RW-1:0]),
    .wdata_i (rf_wdata),
    .re_i    (accept),
    .raddr_i (in_i.data.src_a[RW-1:0]),
    .rdata_o (rf_a_raw)
  );

  tsc_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (s1_q.dest_field[RW-1:0]),
    .wdata_i (rf_wdata),
    .re_i    (accept),
    .raddr_i (in_i.data.src_b[RW-1:0]),
    .rdata_o (rf_b_raw)
  );

  tsc_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (s1_saddr_q),
    .wdata_i (op_b),
    .re_i    (accept),
    .raddr_i (sp_dec),
    .rdata_o (st_raw)
  );

  tsc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dm_we),
    .waddr_i (dm_waddr),
    .wdata_i (dm_wdata),
    .re_i    (accept),
    .raddr_i (in_dm_addr[DW-1:0]),
    .rdata_o (dm_raw)
  );

  // ---------------- execute stage ----------------
  always_comb begin
    is_exec  = tsc_pkg::cmd_e'(s1_q.cmd) == tsc_pkg::CMD_EXEC;
    is_wr    = tsc_pkg::cmd_e'(s1_q.cmd) == tsc_pkg::CMD_WRITE;
    is_rd    = tsc_pkg::cmd_e'(s1_q.cmd) == tsc_pkg::CMD_READ;
    op_load  = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_LOAD);
    op_ldimm = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_LDIMM);
    op_store = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_STORE);
    op_jmp   = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_JMP);
    op_jmpnz = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_JMPNZ);
    op_push  = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_PUSH);
    op_pop   = is_exec && (tsc_pkg::opcode_e'(s1_q.opcode) == tsc_pkg::OP_POP);
  end

  always_comb begin
    op_a = '0;
    if (32'(s1_q.src_a) < NUM_REGS) begin
      if (rf_fwd_vld_q && rf_fwd_addr_q == s1_q.src_a[RW-1:0]) begin
        op_a = rf_fwd_data_q;
      end else if (rf_vld_q[s1_q.src_a[RW-1:0]]) begin
        op_a = rf_a_raw;
      end
    end
    op_b = '0;
    if (32'(s1_q.src_b) < NUM_REGS) begin
      if (rf_fwd_vld_q && rf_fwd_addr_q == s1_q.src_b[RW-1:0]) begin
        op_b = rf_fwd_data_q;
      end else if (rf_vld_q[s1_q.src_b[RW-1:0]]) begin
        op_b = rf_b_raw;
      end
    end
    st_val = '0;
    if (st_fwd_vld_q && st_fwd_addr_q == s1_saddr_q) begin
      st_val = st_fwd_data_q;
    end else if (st_vld_q[s1_saddr_q]) begin
      st_val = st_raw;
    end
    dm_rd_addr = is_exec ? s1_q.src_b : s1_q.mem_addr;
    dm_val = '0;
    if (32'(dm_rd_addr) < DATA_WORDS) begin
      if (dm_fwd_vld_q && dm_fwd_addr_q == dm_rd_addr[DW-1:0]) begin
        dm_val = dm_fwd_data_q;
      end else begin
        dm_val = dm_raw;
      end
    end
  end

  tsc_alu u_alu (
    .opcode_i (s1_q.opcode),
    .a_i      (op_a),
    .b_i      (op_b),
    .res_o    (alu_res)
  );

  assign to_ret = is_exec && alu_res.is_alu && (s1_q.dest_field == 8'(RETURN_REG_INDEX));

  always_comb begin
    rf_wdata = alu_res.result;
    if (op_load) begin
      rf_wdata = dm_val;
    end else if (op_ldimm) begin
      rf_wdata = 32'(s1_q.src_b);
    end else if (op_pop) begin
      rf_wdata = st_val;
    end
    rf_we = advance && (32'(s1_q.dest_field) < NUM_REGS) &&
            (op_load || op_ldimm || op_pop || (is_exec && alu_res.is_alu && !to_ret));
  end

  assign st_we = advance && op_push;

  always_comb begin
    dm_we    = 1'b0;
    dm_waddr = s1_q.mem_addr[DW-1:0];
    dm_wdata = s1_q.mem_wdata;
    if (op_store) begin
      dm_waddr = s1_q.dest_field[DW-1:0];
      dm_wdata = op_b;
      dm_we    = advance && (32'(s1_q.dest_field) < DATA_WORDS);
    end else if (is_wr) begin
      dm_we    = advance && (32'(s1_q.mem_addr) < DATA_WORDS);
    end
  end

  always_comb begin
    npc = pc_q + 8'd1;
    if (op_jmp || (op_jmpnz && op_b != '0)) begin
      npc = s1_q.dest_field;
    end
    pc_d  = is_exec ? npc : pc_q;
    ret_d = to_ret ? alu_res.result : ret_q;

    out_d.next_pc      = pc_d;
    out_d.halted       = ({1'b0, pc_d} + 9'd1) >= 9'(PROG_LEN);
    out_d.return_value = ret_d;
    out_d.read_data    = is_rd ? dm_val : '0;
    out_d.bad_opcode   = is_exec && alu_res.bad;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= '0;
      ret_q        <= '0;
      out_vld_q    <= 1'b0;
      rf_vld_q     <= '0;
      st_vld_q     <= '0;
      rf_fwd_vld_q <= 1'b0;
      st_fwd_vld_q <= 1'b0;
      dm_fwd_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        pc_q      <= pc_d;
        ret_q     <= ret_d;
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (rf_we) begin
        rf_vld_q[s1_q.dest_field[RW-1:0]] <= 1'b1;
        rf_fwd_vld_q <= 1'b1;
      end
      if (st_we) begin
        st_vld_q[s1_saddr_q] <= 1'b1;
        st_fwd_vld_q <= 1'b1;
      end
      if (dm_we) begin
        dm_fwd_vld_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
    if (rf_we) begin
      rf_fwd_addr_q <= s1_q.dest_field[RW-1:0];
      rf_fwd_data_q <= rf_wdata;
    end
    if (st_we) begin
      st_fwd_addr_q <= s1_saddr_q;
      st_fwd_data_q <= op_b;
    end
    if (dm_we) begin
      dm_fwd_addr_q <= dm_waddr;
      dm_fwd_data_q <= dm_wdata;
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  // ---------------- checks ----------------
  a_wb_only_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rf_we || st_we || dm_we) |-> advance)
    else $error("store written without a result moving out");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are held");

  a_pc_only_on_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(advance && is_exec) |=> $stable(pc_q))
    else $error("program counter moved without an executed instruction");

  a_push_moves_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_push) |=> (sp_q == $past(sp_inc)))
    else $error("stack pointer did not advance on push");

endmodule

// ===== rtl/tsc_ram.sv =====
module tsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/tsc_alu.sv =====
module tsc_alu (
  input  logic [7:0]        opcode_i,
  input  logic [31:0]       a_i,
  input  logic [31:0]       b_i,
  output tsc_pkg::alu_res_t res_o
);

  always_comb begin
    res_o = '0;
    unique case (tsc_pkg::opcode_e'(opcode_i))
      tsc_pkg::OP_NOP, tsc_pkg::OP_LOAD, tsc_pkg::OP_LDIMM, tsc_pkg::OP_STORE,
      tsc_pkg::OP_JMP, tsc_pkg::OP_JMPNZ, tsc_pkg::OP_PUSH, tsc_pkg::OP_POP: begin
        res_o = '0;
      end
      tsc_pkg::OP_ADD: begin
        res_o.is_alu = 1'b1;
        res_o.result = a_i + b_i;
      end
      tsc_pkg::OP_SUB: begin
        res_o.is_alu = 1'b1;
        res_o.result = a_i - b_i;
      end
      tsc_pkg::OP_XOR: begin
        res_o.is_alu = 1'b1;
        res_o.result = a_i ^ b_i;
      end
      tsc_pkg::OP_AND: begin
        res_o.is_alu = 1'b1;
        res_o.result = a_i & b_i;
      end
      default: begin
        res_o.bad = 1'b1;
      end
    endcase
  end

endmodule
